[rtl/core/csq_pkg.sv]
// ----------------------------------------------------------------------------
// csq_pkg
// shared types and constants for the counting semaphore with its fifo wait
// queue of blocked thread ids
// ----------------------------------------------------------------------------
package csq_pkg;

  // queue and field sizes
  localparam int QUEUE_DEPTH    = 32;
  localparam int PTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int TID_BITS       = 16;
  localparam int VALUE_BITS     = 16;
  localparam int COUNT_BITS     = 17;
  localparam int IN_DATA_BITS   = 40;
  localparam int OUT_DATA_BITS  = 40;

  // count limits as signed count-width constants
  localparam logic signed [COUNT_BITS-1:0] MAX_COUNT  = COUNT_BITS'(65535);
  localparam logic signed [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(-QUEUE_DEPTH);
  localparam logic signed [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);

  // request kinds, codes five to seven are a plain query
  typedef enum logic [2:0] {
    KIND_INIT    = 3'd0,
    KIND_DESTROY = 3'd1,
    KIND_WAIT    = 3'd2,
    KIND_TRYWAIT = 3'd3,
    KIND_POST    = 3'd4
  } kind_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_HAS_WAITERS = 3'd2,
    ST_QUEUE_FULL  = 3'd3,
    ST_TRY_FAIL    = 3'd4
  } status_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the accepted item and read the queue head
    logic exec;     // apply the request and load the result register
  } cmd_t;

  // one result item, last member in the lowest bits
  typedef struct packed {
    logic                         is_shared;
    logic [TID_BITS-1:0]          wake_thread;
    logic                         wake_valid;
    logic                         caller_blocks;
    logic signed [COUNT_BITS-1:0] count_now;
    status_t                      status;
  } result_t;

endpackage

[rtl/core/counting_semaphore_wait_queue_unit.sv]
// sequencing: an accepted item passes the execute state, then its result is held
//   in the respond state until taken; no new item is accepted meanwhile, as the
//   sequencer runs accept, execute and deliver in turn for each item
// reset: synchronous active-low rst_n clears count, flags and queue pointers;
//   the waiter memory is not cleared and no clearing pass is needed
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_unit
// counting semaphore with a fifo wait queue of blocked thread ids
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] caller_thread, [31:16] init_value, [32] shared_flag
  input  logic [csq_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // [2:0] kind
  input  logic [2:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] status, [19:3] count_now, [20] caller_blocks, [21] wake_valid,
  // [37:22] wake_thread, [38] is_shared
  output logic [csq_pkg::OUT_DATA_BITS-1:0] out_tdata
);

  csq_pkg::cmd_t    cmd;
  csq_pkg::result_t result;

  // sequencer
  csq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // semaphore datapath
  csq_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .kind          (in_tuser),
    .caller_thread (in_tdata[15:0]),
    .init_value    (in_tdata[31:16]),
    .shared_flag   (in_tdata[32]),
    .result        (result)
  );

  // result packing, spare top bit is zero
  assign out_tdata = {1'b0, result};

  // one item in flight at a time
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // an accepted item presents its result once the execute state has passed
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> ##1 out_tvalid)
    else $error("result not presented after acceptance");

  // a queued caller always leaves the count negative with status ok
  a_block_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && result.caller_blocks) |->
      (result.count_now < 0 && result.status == csq_pkg::ST_OK))
    else $error("blocking wait with non-negative count");

  // wake and block never come from one request
  a_wake_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(result.caller_blocks && result.wake_valid))
    else $error("result both blocks and wakes");

endmodule

[rtl/core/csq_ctrl.sv]
// ----------------------------------------------------------------------------
// csq_ctrl
// request sequencer: accept an item, execute it, hold the result until taken
// ----------------------------------------------------------------------------
module csq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output csq_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state_r;
  logic   in_tready_r;
  logic   out_tvalid_r;

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          in_tready_r <= 1'b1;
          if (in_tvalid && in_tready_r) begin
            state_r     <= S_EXEC;
            in_tready_r <= 1'b0;
          end
        end
        S_EXEC: begin
          state_r      <= S_RESP;
          out_tvalid_r <= 1'b1;
        end
        S_RESP: begin
          if (out_tready) begin
            state_r      <= S_IDLE;
            out_tvalid_r <= 1'b0;
            in_tready_r  <= 1'b1;
          end
        end
        default: begin
          state_r      <= S_IDLE;
          in_tready_r  <= 1'b0;
          out_tvalid_r <= 1'b0;
        end
      endcase
    end
  end

  // datapath commands
  always_comb begin
    cmd.capture = in_tvalid && in_tready_r;
    cmd.exec    = (state_r == S_EXEC);
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

endmodule

[rtl/core/csq_datapath.sv]
// ----------------------------------------------------------------------------
// csq_datapath
// semaphore count, flags, queue pointers, waiter memory and result register
// ----------------------------------------------------------------------------
module csq_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  csq_pkg::cmd_t                  cmd,
  input  logic [2:0]                     kind,
  input  logic [csq_pkg::TID_BITS-1:0]   caller_thread,
  input  logic [csq_pkg::VALUE_BITS-1:0] init_value,
  input  logic                           shared_flag,
  output csq_pkg::result_t               result
);

  // latched request
  csq_pkg::kind_t                 kind_r;
  logic [csq_pkg::TID_BITS-1:0]   caller_r;
  logic [csq_pkg::VALUE_BITS-1:0] ival_r;
  logic                           sflag_r;

  // semaphore state
  logic signed [csq_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic                                  valid_r, valid_nxt;
  logic                                  shared_r, shared_nxt;
  logic [csq_pkg::PTR_BITS-1:0]          head_r, head_nxt;
  logic [csq_pkg::PTR_BITS-1:0]          tail_r, tail_nxt;

  // waiter memory and its registered read port
  logic [csq_pkg::TID_BITS-1:0] waiter_mem [csq_pkg::QUEUE_DEPTH];
  logic [csq_pkg::TID_BITS-1:0] rd_data_r;
  logic                         wr_en;

  csq_pkg::result_t                      result_r;
  csq_pkg::status_t                      status_c;
  logic                                  blocks_c;
  logic                                  wvalid_c;
  logic signed [csq_pkg::COUNT_BITS-1:0] ival_ext;

  assign ival_ext = $signed({1'b0, ival_r});

  // latch the item on acceptance
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= csq_pkg::kind_t'(kind);
      caller_r <= caller_thread;
      ival_r   <= init_value;
      sflag_r  <= shared_flag;
    end
  end

  // queue memory: write at tail, read at head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      waiter_mem[tail_r] <= caller_r;
    end
    if (cmd.capture) begin
      rd_data_r <= waiter_mem[head_r];
    end
  end

  // request execution
  always_comb begin
    count_nxt  = count_r;
    valid_nxt  = valid_r;
    shared_nxt = shared_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    status_c   = csq_pkg::ST_OK;
    blocks_c   = 1'b0;
    wvalid_c   = 1'b0;
    wr_en      = 1'b0;
    if (kind_r == csq_pkg::KIND_INIT) begin
      count_nxt  = (ival_ext > csq_pkg::MAX_COUNT) ? csq_pkg::MAX_COUNT : ival_ext;
      head_nxt   = '0;
      tail_nxt   = '0;
      valid_nxt  = 1'b1;
      shared_nxt = sflag_r;
    end else if (!valid_r) begin
      status_c = csq_pkg::ST_INVALID;
    end else begin
      case (kind_r)
        csq_pkg::KIND_DESTROY: begin
          if (count_r < 0) begin
            status_c = csq_pkg::ST_HAS_WAITERS;
          end else begin
            valid_nxt = 1'b0;
          end
        end
        csq_pkg::KIND_WAIT: begin
          if (count_r > 0) begin
            count_nxt = count_r - csq_pkg::COUNT_ONE;
          end else if (count_r <= csq_pkg::COUNT_FULL) begin
            status_c = csq_pkg::ST_QUEUE_FULL;
          end else begin
            wr_en     = cmd.exec;
            tail_nxt  = tail_r + 1'b1;
            count_nxt = count_r - csq_pkg::COUNT_ONE;
            blocks_c  = 1'b1;
          end
        end
        csq_pkg::KIND_TRYWAIT: begin
          if (count_r > 0) begin
            count_nxt = count_r - csq_pkg::COUNT_ONE;
          end else begin
            status_c = csq_pkg::ST_TRY_FAIL;
          end
        end
        csq_pkg::KIND_POST: begin
          if (count_r < 0) begin
            wvalid_c  = 1'b1;
            head_nxt  = head_r + 1'b1;
            count_nxt = count_r + csq_pkg::COUNT_ONE;
          end else if (count_r < csq_pkg::MAX_COUNT) begin
            count_nxt = count_r + csq_pkg::COUNT_ONE;
          end
        end
        default: begin
          // query only
        end
      endcase
    end
  end

  // semaphore state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      valid_r  <= 1'b0;
      shared_r <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
    end else if (cmd.exec) begin
      count_r  <= count_nxt;
      valid_r  <= valid_nxt;
      shared_r <= shared_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result_r.status        <= status_c;
      result_r.count_now     <= count_nxt;
      result_r.caller_blocks <= blocks_c;
      result_r.wake_valid    <= wvalid_c;
      result_r.wake_thread   <= wvalid_c ? rd_data_r : '0;
      result_r.is_shared     <= shared_nxt;
    end
  end

  assign result = result_r;

endmodule
